// ===== rtl/polyline_segment_angle_snap_macros.svh =====
// assertion helpers for the segment angle snap block
`ifndef POLYLINE_SEGMENT_ANGLE_SNAP_MACROS_SVH
`define POLYLINE_SEGMENT_ANGLE_SNAP_MACROS_SVH

// property that must hold on every clock edge out of reset
`define PSAS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication checked on every clock edge out of reset
`define PSAS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/psas_pkg.sv =====
package psas_pkg;

    // fine angles in 1/65536 degree
    localparam int unsigned ATAN_DEPTH = 32;
    localparam logic signed [25:0] FINE_180 = 26'sd11796480;
    localparam logic signed [25:0] FINE_90  = 26'sd5898240;
    localparam logic signed [17:0] COARSE_180 = 18'sd46080;
    localparam logic [31:0] INV_K = 32'd2608131496;

    // datapath width: 33 bit difference, 16 guard bits, cordic growth
    localparam int unsigned VW = 52;
    localparam int unsigned ZW = 27;

    typedef logic signed [VW-1:0] t_vec;
    typedef logic signed [ZW-1:0] t_ang;

    // arctangent table, atan(2^-i) in 1/65536 degree
    function automatic t_ang atan_lut(input logic [4:0] idx);
        t_ang r;
        r = '0;
        case (idx)
            5'd0:  r = 27'sd2949120;
            5'd1:  r = 27'sd1740967;
            5'd2:  r = 27'sd919879;
            5'd3:  r = 27'sd466945;
            5'd4:  r = 27'sd234379;
            5'd5:  r = 27'sd117304;
            5'd6:  r = 27'sd58666;
            5'd7:  r = 27'sd29335;
            5'd8:  r = 27'sd14668;
            5'd9:  r = 27'sd7334;
            5'd10: r = 27'sd3667;
            5'd11: r = 27'sd1833;
            5'd12: r = 27'sd917;
            5'd13: r = 27'sd458;
            5'd14: r = 27'sd229;
            5'd15: r = 27'sd115;
            5'd16: r = 27'sd57;
            5'd17: r = 27'sd29;
            5'd18: r = 27'sd14;
            5'd19: r = 27'sd7;
            5'd20: r = 27'sd4;
            5'd21: r = 27'sd2;
            5'd22: r = 27'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // control from sequencer into the cordic unit
    typedef struct packed {
        logic load;
        logic step;
        logic rotate;
    } t_cordic_ctrl;

endpackage

// ===== rtl/psas_cordic.sv =====
module psas_cordic (
    input  logic                  i_clk,
    input  psas_pkg::t_cordic_ctrl i_ctrl,
    input  logic [4:0]            i_shift,
    input  psas_pkg::t_vec        i_x,
    input  psas_pkg::t_vec        i_y,
    input  psas_pkg::t_ang        i_z,
    output psas_pkg::t_vec        o_x,
    output psas_pkg::t_vec        o_y,
    output psas_pkg::t_ang        o_z
);

    psas_pkg::t_vec r_x, r_y, n_x, n_y, sx, sy;
    psas_pkg::t_ang r_z, n_z, a;
    logic dir;

    // one shared micro-rotation per cycle
    always_comb begin
        sx  = r_x >>> i_shift;
        sy  = r_y >>> i_shift;
        a   = psas_pkg::atan_lut(i_shift);
        dir = i_ctrl.rotate ? !r_z[psas_pkg::ZW-1] : r_y[psas_pkg::VW-1];
        n_x = r_x; n_y = r_y; n_z = r_z;
        if (i_ctrl.load) begin
            n_x = i_x; n_y = i_y; n_z = i_z;
        end else if (i_ctrl.step) begin
            if (dir) begin
                n_x = r_x - sy; n_y = r_y + sx; n_z = r_z - a;
            end else begin
                n_x = r_x + sy; n_y = r_y - sx; n_z = r_z + a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ===== rtl/polyline_segment_angle_snap.sv =====
// Segment angle snap. One vertex is taken, then the block is busy. A snapped vertex
// makes two passes of one shared CORDIC micro-rotation unit, vectoring then rotation,
// at one shift-add step a cycle. Between the passes come a grid compare against each
// of the four grid angles, the threshold check and the load of the rotation pass.
// Then the two 1/K multiplies run, each as high and low halves on one multiplier,
// and last come the output state and the return to idle. An unsnapped vertex skips
// the rotation pass and the multiplies; a first or zero-length vertex goes straight
// to the output. The result sits in an output register. While it waits, the input
// is stalled, since the next vertex depends on its anchor.
module polyline_segment_angle_snap #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic               i_first_point,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic               o_snapped,
    output logic [1:0]         o_grid_index
);

`include "polyline_segment_angle_snap_macros.svh"

    localparam logic [1:0] CFG_OVR = 2'd0;
    localparam logic [1:0] CFG_BASE = 2'd1;
    localparam logic [1:0] CFG_THR = 2'd2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_VEC  = 4'd1;
    localparam logic [3:0] S_GRID = 4'd2;
    localparam logic [3:0] S_PICK = 4'd3;
    localparam logic [3:0] S_ROT  = 4'd4;
    localparam logic [3:0] S_MULX = 4'd5;
    localparam logic [3:0] S_MULY = 4'd6;
    localparam logic [3:0] S_SUM  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_VLD  = 4'd9;
    localparam logic [3:0] S_MULX2 = 4'd10;
    localparam logic [3:0] S_MULY2 = 4'd11;

    localparam int SW = $clog2(CORDIC_STEPS + 1);

    // configuration registers
    logic               r_ovr;
    logic signed [16:0] r_base;
    logic [15:0]        r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovr  <= 1'b0;
            r_base <= '0;
            r_thr  <= 16'd2560;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OVR:  r_ovr  <= i_cfg_data[0];
                CFG_BASE: r_base <= i_cfg_data;
                CFG_THR:  r_thr  <= i_cfg_data[15:0];
                default:  ;
            endcase
        end
    end

    logic [3:0]         r_state;
    logic [SW-1:0]      r_cnt;
    logic [1:0]         r_g;
    logic signed [31:0] r_ax, r_ay, r_px, r_py;
    logic               r_av, r_fold;
    psas_pkg::t_vec     r_vx, r_vy;
    psas_pkg::t_ang     r_orient, r_delta;
    logic [25:0]        r_mind;
    logic [1:0]         r_best;
    logic [63:0]        r_prod;
    logic signed [31:0] r_ox, r_oy;
    logic               r_osn, r_ovld;
    logic [1:0]         r_oidx;

    psas_pkg::t_cordic_ctrl ctrl;
    psas_pkg::t_vec         c_x, c_y, ld_x, ld_y;
    psas_pkg::t_ang         c_z, ld_z;

    logic accept;
    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || (r_ovld && i_stall);

    // segment difference and fold
    logic signed [32:0] dx, dy;
    assign dx = 33'(i_point_x) - 33'(r_ax);
    assign dy = 33'(i_point_y) - 33'(r_ay);

    // grid angle reduced into [0,180) coarse degrees
    logic signed [17:0] graw, goff, gred;
    always_comb begin
        unique case (r_g)
            2'd0: goff = 18'sd0;
            2'd1: goff = 18'sd23040;
            2'd2: goff = 18'sd11520;
            default: goff = -18'sd11520;
        endcase
        graw = (r_ovr ? 18'(r_base) : 18'sd0) + goff;
        // range is (-2*180, 2*180): at most two corrections
        gred = graw;
        if (gred >= psas_pkg::COARSE_180) gred = gred - psas_pkg::COARSE_180;
        if (gred < 0) gred = gred + psas_pkg::COARSE_180;
        if (gred >= psas_pkg::COARSE_180) gred = gred - psas_pkg::COARSE_180;
        if (gred < 0) gred = gred + psas_pkg::COARSE_180;
    end

    // distance of orientation to current grid angle
    psas_pkg::t_ang go, diff, ang_dist;
    assign go = psas_pkg::t_ang'({gred, 8'd0});
    always_comb begin
        diff = (r_orient > go) ? r_orient - go : go - r_orient;
        ang_dist = (diff < 27'(psas_pkg::FINE_90)) ? diff : 27'(psas_pkg::FINE_180) - diff;
    end

    // shared 1/K multiplier: magnitude split into high and low parts
    logic signed [52:0] mval;
    logic [52:0]        mmag;
    logic [63:0]        mprod;
    assign mval = (r_state == S_MULX || r_state == S_MULX2) ? 53'(c_x) : 53'(c_y);
    assign mmag = mval[52] ? 53'(-mval) : mval;
    // high part at most 33 bits, low part 20 bits
    assign mprod = (r_state == S_MULX || r_state == S_MULY) ?
        64'(mmag[52:20]) * 64'(psas_pkg::INV_K) :
        64'(mmag[19:0]) * 64'(psas_pkg::INV_K);

    logic signed [52:0] mres, rnd;
    logic [63:0] hsum;
    assign hsum = r_prod + (mprod >> 20);
    assign mres = mval[52] ^ r_fold ? -53'(hsum >> 12) : 53'(hsum >> 12);
    assign rnd  = (mres + 53'sd32768) >>> 16;

    logic signed [33:0] sumv;
    assign sumv = 34'(r_state == S_MULY2 ? r_ay : r_ax) + 34'(rnd);
    logic signed [31:0] satv;
    always_comb begin
        if (sumv > 34'sd2147483647) satv = 32'sh7fffffff;
        else if (sumv < -34'sd2147483648) satv = 32'sh80000000;
        else satv = sumv[31:0];
    end

    // cordic unit control
    always_comb begin
        ctrl = '0;
        ctrl.rotate = (r_state == S_ROT);
        ld_x = r_vx; ld_y = r_vy; ld_z = '0;
        if (r_state == S_PICK) begin
            ctrl.load = 1'b1;
            ld_z = r_delta;
        end
        if ((r_state == S_VEC || r_state == S_ROT) && r_cnt != SW'(CORDIC_STEPS))
            ctrl.step = 1'b1;
        if (r_state == S_IDLE) ctrl.load = 1'b1;
        if (r_state == S_IDLE) begin
            ld_x = (dx[32] ? -psas_pkg::t_vec'(dx) : psas_pkg::t_vec'(dx)) <<< 16;
            ld_y = (dx[32] ? -psas_pkg::t_vec'(dy) : psas_pkg::t_vec'(dy)) <<< 16;
        end
    end

    psas_cordic u_cordic (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_shift(5'(r_cnt)),
        .i_x    (ld_x),
        .i_y    (ld_y),
        .i_z    (ld_z),
        .o_x    (c_x),
        .o_y    (c_y),
        .o_z    (c_z)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_av    <= 1'b0;
            r_ax    <= '0;
            r_ay    <= '0;
            r_ovld  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (r_ovld && !i_stall) r_ovld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (accept) begin
                        r_px <= i_point_x;
                        r_py <= i_point_y;
                        r_fold <= dx[32];
                        r_vx <= (dx[32] ? -psas_pkg::t_vec'(dx) : psas_pkg::t_vec'(dx)) <<< 16;
                        r_vy <= (dx[32] ? -psas_pkg::t_vec'(dy) : psas_pkg::t_vec'(dy)) <<< 16;
                        if (i_first_point || !r_av || (dx == 0 && dy == 0)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_VEC;
                        end
                    end
                end
                S_VEC: begin
                    if (r_cnt == SW'(CORDIC_STEPS)) begin
                        r_orient <= c_z[psas_pkg::ZW-1] ?
                            c_z + 27'(psas_pkg::FINE_180) : c_z;
                        r_g <= 2'd0;
                        r_mind <= 26'(psas_pkg::FINE_180);
                        r_best <= 2'd0;
                        r_delta <= '0;
                        r_state <= S_GRID;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_GRID: begin
                    if (26'(ang_dist) < r_mind) begin
                        r_mind <= 26'(ang_dist);
                        r_best <= r_g;
                        r_delta <= go - r_orient;
                    end
                    r_g <= r_g + 2'd1;
                    if (r_g == 2'd3) r_state <= S_SUM;
                end
                S_SUM: begin
                    // threshold check and delta wrap
                    if (!r_ovr && (r_mind > 26'({r_thr, 8'd0}))) begin
                        r_state <= S_OUT;
                    end else begin
                        if (r_delta >= 27'(psas_pkg::FINE_90))
                            r_delta <= r_delta - 27'(psas_pkg::FINE_180);
                        else if (r_delta < -27'(psas_pkg::FINE_90))
                            r_delta <= r_delta + 27'(psas_pkg::FINE_180);
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_cnt <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (r_cnt == SW'(CORDIC_STEPS)) r_state <= S_MULX;
                    else r_cnt <= r_cnt + 1'b1;
                end
                S_MULX: begin
                    r_prod <= mprod;
                    r_state <= S_MULX2;
                end
                S_MULX2: begin
                    r_ox <= satv;
                    r_state <= S_MULY;
                end
                S_MULY: begin
                    r_prod <= mprod;
                    r_state <= S_MULY2;
                end
                S_MULY2: begin
                    r_oy <= satv;
                    r_state <= S_VLD;
                end
                S_OUT: begin
                    r_ox <= r_px;
                    r_oy <= r_py;
                    r_osn <= 1'b0;
                    r_oidx <= 2'd0;
                    r_ax <= r_px;
                    r_ay <= r_py;
                    r_av <= 1'b1;
                    r_ovld <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_VLD: begin
                    r_osn <= 1'b1;
                    r_oidx <= r_best;
                    r_ax <= r_ox;
                    r_ay <= r_oy;
                    r_av <= 1'b1;
                    r_ovld <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovld;
    assign o_out_x = r_ox;
    assign o_out_y = r_oy;
    assign o_snapped = r_osn;
    assign o_grid_index = r_oidx;

    // checks
    `PSAS_ASSERT_IMPL(a_busy_stall, r_state != S_IDLE, o_stall, "busy but not stalled")
    `PSAS_ASSERT_IMPL(a_idx_zero, o_valid && !o_snapped, o_grid_index == 2'd0, "index without snap")
    `PSAS_ASSERT_IMPL(a_out_anchor, $rose(o_valid), o_out_x == r_ax && o_out_y == r_ay, "anchor mismatch")
    `PSAS_ASSERT_ALWAYS(a_cnt_range, r_cnt <= SW'(CORDIC_STEPS), "step count overrun")

endmodule

// ===== tb/sv/psas_tb_pkg.sv =====
package psas_tb_pkg;

    // register map of the configuration port
    typedef enum logic [1:0] {
        REG_OVERRIDE   = 2'd0,
        REG_BASE_ANGLE = 2'd1,
        REG_THRESHOLD  = 2'd2,
        REG_UNUSED     = 2'd3
    } snap_reg_e;

endpackage

// ===== tb/sv/segment_snap_checker.sv =====
module segment_snap_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic               i_first_point,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] o_out_x,
    input  logic signed [31:0] o_out_y,
    input  logic               o_snapped,
    input  logic [1:0]         o_grid_index,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int     STEPS    = 24;
    localparam longint GUARD    = 65536;
    localparam longint DEG180   = 11796480;
    localparam longint DEG90    = 5898240;
    localparam int     COARSE   = 46080;
    localparam longint unsigned RECIP_GAIN = 64'd2608131496;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               snapped;
        logic [1:0]         grid;
    } vertex_t;

    // atan(2^-i) in 1/65536 degree
    longint arctan_fine [0:31] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };
    int grid_offset [0:3] = '{0, 23040, 11520, -11520};

    vertex_t            expected_vertices[$];
    logic               override_on;
    logic signed [16:0] base_coarse;
    logic [15:0]        threshold_coarse;
    longint             anchor_x;
    longint             anchor_y;
    logic               anchor_ok;

    function automatic longint scale_by_recip_gain(input longint v);
        longint unsigned m, hi, lo, r;
        m  = (v < 0) ? longint'(-v) : longint'(v);
        hi = m >> 20;
        lo = m & 64'hFFFFF;
        r  = (hi * RECIP_GAIN + ((lo * RECIP_GAIN) >> 20)) >> 12;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // snap one vertex against the anchor and move the anchor
    function automatic vertex_t snap_vertex(input longint px, input longint py,
                                            input logic first);
        vertex_t res;
        longint  dx, dy, vx, vy, cx, cy, nx, ny, z, orient, thr, min_dist, delta;
        longint  go, diff, ang_dist, rx, ry;
        int      base_i, raw, best;
        logic    fold;
        res = '{x: px[31:0], y: py[31:0], snapped: 1'b0, grid: 2'd0};
        dx  = px - anchor_x;
        dy  = py - anchor_y;
        if (!(first || !anchor_ok || (dx == 0 && dy == 0))) begin
            fold = dx < 0;
            vx = (fold ? -dx : dx) * GUARD;
            vy = (fold ? -dy : dy) * GUARD;
            // vectoring pass: angle of the segment
            cx = vx; cy = vy; z = 0;
            for (int i = 0; i < STEPS; i++) begin
                if (cy < 0) begin
                    nx = cx - (cy >>> i); ny = cy + (cx >>> i); z -= arctan_fine[i];
                end else begin
                    nx = cx + (cy >>> i); ny = cy - (cx >>> i); z += arctan_fine[i];
                end
                cx = nx; cy = ny;
            end
            orient = (z < 0) ? z + DEG180 : z;
            // nearest grid direction modulo 180
            base_i = override_on ? int'(base_coarse) : 0;
            thr = override_on ? DEG180 : longint'(threshold_coarse) * 256;
            min_dist = DEG180;
            delta = 0;
            best = 0;
            for (int g = 0; g < 4; g++) begin
                raw = (base_i + grid_offset[g]) % COARSE;
                if (raw < 0) raw += COARSE;
                go = longint'(raw) * 256;
                diff = (orient > go) ? orient - go : go - orient;
                ang_dist = (diff < DEG90) ? diff : DEG180 - diff;
                if (ang_dist < min_dist) begin
                    min_dist = ang_dist;
                    best = g;
                    delta = go - orient;
                end
            end
            if (min_dist <= thr) begin
                if (delta >= DEG90) delta -= DEG180;
                if (delta < -DEG90) delta += DEG180;
                // rotation pass onto the grid direction
                cx = vx; cy = vy; z = delta;
                for (int i = 0; i < STEPS; i++) begin
                    if (z >= 0) begin
                        nx = cx - (cy >>> i); ny = cy + (cx >>> i); z -= arctan_fine[i];
                    end else begin
                        nx = cx + (cy >>> i); ny = cy - (cx >>> i); z += arctan_fine[i];
                    end
                    cx = nx; cy = ny;
                end
                rx = scale_by_recip_gain(cx);
                ry = scale_by_recip_gain(cy);
                if (fold) begin
                    rx = -rx;
                    ry = -ry;
                end
                rx = clamp32(anchor_x + ((rx + GUARD / 2) >>> 16));
                ry = clamp32(anchor_y + ((ry + GUARD / 2) >>> 16));
                res = '{x: rx[31:0], y: ry[31:0], snapped: 1'b1, grid: best[1:0]};
            end
        end
        anchor_x  = longint'(res.x);
        anchor_y  = longint'(res.y);
        anchor_ok = 1'b1;
        return res;
    endfunction

    assign o_pending = expected_vertices.size();

    // config shadow, prediction on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        vertex_t want;
        vertex_t got;
        if (!i_rst_n) begin
            override_on      = 1'b0;
            base_coarse      = '0;
            threshold_coarse = 16'd2560;
            anchor_x         = 0;
            anchor_y         = 0;
            anchor_ok        = 1'b0;
            expected_vertices.delete();
        end else begin
            if (i_cfg_we) begin
                case (psas_tb_pkg::snap_reg_e'(i_cfg_index))
                    psas_tb_pkg::REG_OVERRIDE:   override_on = i_cfg_data[0];
                    psas_tb_pkg::REG_BASE_ANGLE: base_coarse = i_cfg_data;
                    psas_tb_pkg::REG_THRESHOLD:  threshold_coarse = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                expected_vertices.push_back(snap_vertex(longint'(i_point_x),
                                                        longint'(i_point_y), i_first_point));
            if (o_valid && !i_stall) begin
                got = '{x: o_out_x, y: o_out_y, snapped: o_snapped, grid: o_grid_index};
                if (expected_vertices.size() == 0) begin
                    o_fail_count++;
                    $display("%0t unexpected vertex x=%0d y=%0d snapped=%0d grid=%0d",
                             $time, got.x, got.y, got.snapped, got.grid);
                end else begin
                    want = expected_vertices.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        $display("%0t mismatch exp x=%0d y=%0d snapped=%0d grid=%0d",
                                 $time, want.x, want.y, want.snapped, want.grid);
                        $display("%0t          got x=%0d y=%0d snapped=%0d grid=%0d",
                                 $time, got.x, got.y, got.snapped, got.grid);
                    end
                end
            end
        end
    end

    initial o_fail_count = 0;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  SETTLE      = 70;
    localparam longint PMAX     = 64'sd2147483647;
    localparam longint PMIN     = -64'sd2147483648;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic               i_first_point;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [16:0]        i_cfg_data;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic               o_snapped;
    logic [1:0]         o_grid_index;

    int     fail_count;
    int     pending;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     cycles = 0;
    longint last_x;
    longint last_y;

    polyline_segment_angle_snap u_top (.*);

    segment_snap_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_point_x, .i_point_y, .i_first_point,
        .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_valid, .i_stall, .o_out_x, .o_out_y,
        .o_snapped, .o_grid_index, .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL polyline_segment_angle_snap");
            $finish;
        end
    end

    function automatic longint clamp32(input longint v);
        return (v > PMAX) ? PMAX : (v < PMIN) ? PMIN : v;
    endfunction

    // one vertex transfer, with an optional sender gap in front
    task automatic send_point(input longint px, input longint py, input logic first);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_point_x     <= px[31:0];
        i_point_y     <= py[31:0];
        i_first_point <= first;
        last_x = px;
        last_y = py;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic write_reg(input psas_tb_pkg::snap_reg_e idx, input logic [16:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // drain all results, then let the block finish any work in flight
    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_grid(input logic ovr, input int base, input int thr, input logic spare);
        write_reg(psas_tb_pkg::REG_OVERRIDE, {16'd0, ovr});
        write_reg(psas_tb_pkg::REG_BASE_ANGLE, base[16:0]);
        write_reg(psas_tb_pkg::REG_THRESHOLD, thr[16:0]);
        if (spare)
            write_reg(psas_tb_pkg::REG_UNUSED, 17'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // next vertex of a random polyline, mostly relative to the last one
    task automatic random_point;
        longint dx, dy, r;
        int     k;
        logic   first;
        first = ($urandom_range(99) < 5);
        dx = 0;
        dy = 0;
        case ($urandom_range(9))
            0, 1: begin
                dx = longint'($urandom_range(2048)) - 1024;
                dy = longint'($urandom_range(2048)) - 1024;
            end
            2: begin
                dx = longint'($urandom_range(1 << 21)) - (1 << 20);
                dy = longint'($urandom_range(1 << 21)) - (1 << 20);
            end
            3, 4, 5: begin
                // close to one of the eight compass directions
                r = $urandom_range(1 << ($urandom_range(4, 22)));
                k = $urandom_range(7);
                dx = (k == 2 || k == 6) ? 0 : (k > 2 && k < 6) ? -r : r;
                dy = (k == 0 || k == 4) ? 0 : (k < 4) ? r : -r;
                dx += longint'($urandom_range(r / 4 + 2)) - (r / 8 + 1);
                dy += longint'($urandom_range(r / 4 + 2)) - (r / 8 + 1);
            end
            6: begin
                last_x = longint'(signed'($urandom));
                last_y = longint'(signed'($urandom));
            end
            7: begin
                dx = longint'($urandom_range(6)) - 3;
                dy = longint'($urandom_range(6)) - 3;
            end
            8: ;
            default: begin
                dx = $urandom_range(1) ? PMAX : PMIN;
                dy = $urandom_range(1) ? PMAX : PMIN;
            end
        endcase
        send_point(clamp32(last_x + dx), clamp32(last_y + dy), first);
    endtask

    initial begin
        int setting;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_point_x     = '0;
        i_point_y     = '0;
        i_first_point = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        send_idle_pct = 11;
        recv_idle_pct = 51;
        last_x        = 0;
        last_y        = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: no anchor yet, zero length, axes, diagonals, folding, extremes
        send_point(1000, 2000, 1'b0);
        send_point(1000, 2000, 1'b0);
        send_point(0, 0, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(2560, 30, 1'b0);
        send_point(2560, 5000, 1'b0);
        send_point(5120, 7600, 1'b0);
        send_point(-3000, 7700, 1'b0);
        send_point(-3000, -9000, 1'b0);
        send_point(-3100, 0, 1'b0);
        send_point(-3100, 4000, 1'b0);
        send_point(7000, 5250, 1'b0);
        send_point(8000, 5426, 1'b0);
        send_point(8000, 5400, 1'b0);
        send_point(PMIN, PMIN, 1'b1);
        send_point(PMAX, PMAX, 1'b0);
        send_point(PMAX, PMIN, 1'b0);
        send_point(PMIN, PMAX, 1'b0);
        send_point(PMAX - 100, PMAX, 1'b1);
        send_point(PMIN, PMAX - 300, 1'b0);
        send_point(-1, -1, 1'b1);
        send_point(-1, 0, 1'b0);

        // random polylines under several grid settings and idling patterns
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 11 : 0;
            for (int blk = 0; blk < 3; blk++) begin
                drain();
                setting = phase * 3 + blk;
                case (setting)
                    0: set_grid(1'b0, 0, 0, 1'b1);
                    1: set_grid(1'b0, 0, 46080, 1'b0);
                    2: set_grid(1'b1, -46080, 0, 1'b0);
                    3: set_grid(1'b1, 46080, 46080, 1'b1);
                    4: set_grid(1'b0, 0, 5760, 1'b0);
                    default: set_grid(1'($urandom), $urandom_range(92160) - 46080,
                                      ($urandom_range(1) ? $urandom_range(46080)
                                                         : $urandom_range(3000)), 1'b1);
                endcase
                for (int n = 0; n < 56; n++)
                    random_point();
            end
        end

        drain();
        if (fail_count == 0)
            $display("PASS polyline_segment_angle_snap");
        else
            $display("FAIL polyline_segment_angle_snap");
        $finish;
    end

endmodule

// ===== polyline_segment_angle_snap.f =====
+incdir+rtl
rtl/psas_pkg.sv
rtl/psas_cordic.sv
rtl/polyline_segment_angle_snap.sv
tb/sv/psas_tb_pkg.sv
tb/sv/segment_snap_checker.sv
tb/sv/testbench.sv
